// ===== hw/rtl/windowed_average_with_missing_defines.svh =====
// Assertion macros shared by the windowed average block.
`ifndef WINDOWED_AVERAGE_WITH_MISSING_DEFINES_SVH
`define WINDOWED_AVERAGE_WITH_MISSING_DEFINES_SVH

// Same-cycle implication checked on every rising edge outside reset.
`define WAM_ASSERT_NOW(label, cond_a, cond_b) \
  label: assert property (@(posedge clk) disable iff (rst) (cond_a) |-> (cond_b)) \
    else $error("windowed average check failed");

// Next-cycle implication checked on every rising edge outside reset.
`define WAM_ASSERT_NEXT(label, cond_a, cond_b) \
  label: assert property (@(posedge clk) disable iff (rst) (cond_a) |=> (cond_b)) \
    else $error("windowed average check failed");

`endif

// ===== hw/rtl/wam_pkg.sv =====
// Package with the transaction types, register indexes and sequencer states.
`timescale 1ns / 1ps

package wam_pkg;

  // Fixed field widths of the transactions.
  localparam int SAMPLE_W   = 16;
  localparam int PIDX_W     = 5;
  localparam int WFRAMES_W  = 5;
  localparam int CFG_IDX_W  = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_FRAMES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NODATA_MARKER = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [WFRAMES_W-1:0] WINDOW_FRAMES_RST = 5'd4;
  localparam logic [SAMPLE_W-1:0]  NODATA_MARKER_RST = 16'h8000;

  // Input item codes.
  localparam logic FUNC_SAMPLE  = 1'b0;
  localparam logic FUNC_MISSING = 1'b1;

  typedef struct packed {
    logic                        func;
    logic signed [SAMPLE_W-1:0]  sample;
  } in_item_t;

  typedef struct packed {
    logic [PIDX_W-1:0]           probe_index;
    logic signed [SAMPLE_W-1:0]  average;
    logic                        last_of_run;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_RD,
    S_ACC,
    S_ABS,
    S_DIV,
    S_SIGN,
    S_OUT
  } state_t;

endpackage

// ===== hw/rtl/windowed_average_with_missing.sv =====
// Top level of the windowed per-probe average with missing-sample exclusion.
//
// Input channel (in_valid / in_stall / in_data): each transaction carries one
// probe sample in frame order, or reports a missing frame. A sample that does
// not complete a frame is stored in the frame memory. A frame-completing sample or a
// missing-frame report starts a run of PROBES averages on the output channel
// (out_valid / out_stall / out_data), the last flagged by last_of_run.
// During a run in_stall stays high. For each probe, one shared adder/subtractor
// sums the window from the frame memory (a registered read, then an add, for
// each frame), then runs a restoring divide at one quotient bit per cycle;
// SUMW, the accumulator width, is 21 by default. A probe without a valid
// sample skips the divide, and an empty window skips both steps.
// A finished average waits in the output register; while out_stall is high
// the sequencer holds, and the next transaction is taken as soon as the last
// average of a run sits in that register.
// Reset (rst, synchronous) empties the window and restores window_frames = 4
// and nodata_marker = -32768; the frame memory is not cleared and no slot is
// read before it is written. Configuration (cfg_we / cfg_index / cfg_data)
// is to be written by the user only while the block is idle; the block does not enforce this.
`timescale 1ns / 1ps
`include "windowed_average_with_missing_defines.svh"

module windowed_average_with_missing #(
  parameter int PROBES     = 32,
  parameter int WINDOW_MAX = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  wam_pkg::in_item_t                      in_data,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output wam_pkg::out_item_t                     out_data,
  input  logic                                   cfg_we,
  input  logic [wam_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [wam_pkg::SAMPLE_W-1:0]           cfg_data
);

  import wam_pkg::*;

  localparam int PW    = (PROBES > 1) ? $clog2(PROBES) : 1;
  localparam int SLW   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int HW    = $clog2(WINDOW_MAX + 2);
  localparam int CW    = $clog2(WINDOW_MAX + 1);
  localparam int SUMW  = 17 + $clog2(WINDOW_MAX);
  localparam int ALUW  = SUMW + 1;
  localparam int DEPTH = WINDOW_MAX * PROBES;
  localparam int ADRW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DCW   = $clog2(SUMW + 1);
  localparam int CMPW  = ((HW > WFRAMES_W) ? HW : WFRAMES_W) + 1;

  // Control state.
  state_t                state, state_next;
  logic [HW-1:0]         frames_held;
  logic [SLW-1:0]        oldest_slot;
  logic [PW-1:0]         fill_position;
  logic [WFRAMES_W-1:0]  window_frames;
  logic [SAMPLE_W-1:0]   nodata_marker;

  // Run sequencing and datapath registers.
  logic [PW-1:0]         probe;
  logic [HW-1:0]         frame_idx;
  logic [SLW-1:0]        slot_cur;
  logic signed [SUMW-1:0] sum;
  logic [CW-1:0]         cnt;
  logic [SUMW-1:0]       dvd;
  logic [SUMW-1:0]       rem;
  logic                  neg;
  logic [DCW-1:0]        div_left;
  logic [SAMPLE_W-1:0]   res;
  logic [SAMPLE_W-1:0]   rdata;

  // Frame memory, one slot of PROBES samples per window frame.
  logic [SAMPLE_W-1:0]   mem [DEPTH];

  logic                  in_fire;
  logic                  out_load;
  logic                  frame_end;
  logic                  acc_hit;
  logic                  acc_last;
  logic [SUMW-1:0]       rem_shift;
  logic [HW:0]           wr_slot_sum;
  logic [SLW-1:0]        wr_slot;
  logic [ADRW-1:0]       wr_addr;
  logic [ADRW-1:0]       rd_addr;
  logic [CMPW-1:0]       cap;
  logic                  over_cap;

  // Shared adder/subtractor.
  logic signed [ALUW-1:0] alu_a, alu_b, alu_y;
  logic                   alu_sub;

  function automatic logic [SLW-1:0] slot_inc(input logic [SLW-1:0] s);
    logic [SLW-1:0] r;
    r = (s == SLW'(WINDOW_MAX - 1)) ? '0 : SLW'(s + SLW'(1));
    return r;
  endfunction

  // Handshake and address arithmetic.
  always_comb begin
    in_stall    = (state != S_IDLE);
    in_fire     = in_valid && !in_stall;
    out_load    = (state == S_OUT) && (!out_valid || !out_stall);
    frame_end   = (fill_position == PW'(PROBES - 1));
    acc_hit     = (rdata != nodata_marker);
    acc_last    = ((frame_idx + HW'(1)) == frames_held);
    rem_shift   = {rem[SUMW-2:0], dvd[SUMW-1]};
    wr_slot_sum = (HW + 1)'(oldest_slot) + (HW + 1)'(frames_held);
    if (wr_slot_sum >= (HW + 1)'(WINDOW_MAX)) begin
      wr_slot = SLW'(wr_slot_sum - (HW + 1)'(WINDOW_MAX));
    end else begin
      wr_slot = SLW'(wr_slot_sum);
    end
    wr_addr = ADRW'(wr_slot) * ADRW'(PROBES) + ADRW'(fill_position);
    rd_addr = ADRW'(slot_cur) * ADRW'(PROBES) + ADRW'(probe);
    if (CMPW'(window_frames) > CMPW'(WINDOW_MAX)) begin
      cap = CMPW'(WINDOW_MAX);
    end else begin
      cap = CMPW'(window_frames);
    end
    over_cap = (CMPW'(frames_held) + CMPW'(1)) > cap;
  end

  // Operand selection for the shared unit.
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state)
      S_ACC: begin
        alu_a = ALUW'(sum);
        alu_b = ALUW'($signed(rdata));
      end
      S_ABS: begin
        alu_b   = ALUW'(sum);
        alu_sub = 1'b1;
      end
      S_DIV: begin
        alu_a   = $signed({1'b0, rem_shift});
        alu_b   = $signed({{(ALUW - CW){1'b0}}, cnt});
        alu_sub = 1'b1;
      end
      S_SIGN: begin
        alu_b   = $signed({1'b0, dvd});
        alu_sub = 1'b1;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
    alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire && (in_data.func == FUNC_MISSING || frame_end)) begin
          state_next = S_START;
        end
      end
      S_START: begin
        state_next = (frames_held == '0) ? S_OUT : S_RD;
      end
      S_RD: begin
        state_next = S_ACC;
      end
      S_ACC: begin
        if (!acc_last) begin
          state_next = S_RD;
        end else if (cnt == '0 && !acc_hit) begin
          state_next = S_OUT;
        end else begin
          state_next = S_ABS;
        end
      end
      S_ABS: begin
        state_next = S_DIV;
      end
      S_DIV: begin
        if (div_left == DCW'(1)) begin
          state_next = S_SIGN;
        end
      end
      S_SIGN: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          state_next = (probe == PW'(PROBES - 1)) ? S_IDLE : S_START;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Window bookkeeping, configuration and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_held   <= '0;
      oldest_slot   <= '0;
      fill_position <= '0;
      window_frames <= WINDOW_FRAMES_RST;
      nodata_marker <= NODATA_MARKER_RST;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WINDOW_FRAMES: window_frames <= cfg_data[WFRAMES_W-1:0];
          REG_NODATA_MARKER: nodata_marker <= cfg_data;
          default:           window_frames <= window_frames;
        endcase
      end
      if (in_fire) begin
        if (in_data.func == FUNC_MISSING) begin
          fill_position <= '0;
          if (frames_held != '0) begin
            oldest_slot <= slot_inc(oldest_slot);
            frames_held <= frames_held - HW'(1);
          end
        end else if (frame_end) begin
          // Commit the frame; if that overfills the window the oldest goes.
          fill_position <= '0;
          if (over_cap) begin
            oldest_slot <= slot_inc(oldest_slot);
          end else begin
            frames_held <= frames_held + HW'(1);
          end
        end else begin
          fill_position <= fill_position + PW'(1);
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Frame memory write and registered read.
  always_ff @(posedge clk) begin
    if (in_fire && in_data.func == FUNC_SAMPLE) begin
      mem[wr_addr] <= in_data.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RD) begin
      rdata <= mem[rd_addr];
    end
  end

  // Accumulate, divide and result datapath.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          probe <= '0;
        end
      end
      S_START: begin
        sum       <= '0;
        cnt       <= '0;
        frame_idx <= '0;
        slot_cur  <= oldest_slot;
        res       <= nodata_marker;
      end
      S_ACC: begin
        if (acc_hit) begin
          sum <= alu_y[SUMW-1:0];
          cnt <= cnt + CW'(1);
        end
        frame_idx <= frame_idx + HW'(1);
        slot_cur  <= slot_inc(slot_cur);
      end
      S_ABS: begin
        // Divide magnitudes; the sign is put back at the end.
        neg      <= sum[SUMW-1];
        dvd      <= sum[SUMW-1] ? alu_y[SUMW-1:0] : sum;
        rem      <= '0;
        div_left <= DCW'(SUMW);
      end
      S_DIV: begin
        // One restoring step: keep the difference when it did not borrow.
        if (!alu_y[ALUW-1]) begin
          rem <= alu_y[SUMW-1:0];
          dvd <= {dvd[SUMW-2:0], 1'b1};
        end else begin
          rem <= rem_shift;
          dvd <= {dvd[SUMW-2:0], 1'b0};
        end
        div_left <= div_left - DCW'(1);
      end
      S_SIGN: begin
        res <= neg ? alu_y[SAMPLE_W-1:0] : dvd[SAMPLE_W-1:0];
      end
      S_OUT: begin
        if (out_load) begin
          out_data.probe_index <= PIDX_W'(probe);
          out_data.average     <= res;
          out_data.last_of_run <= (probe == PW'(PROBES - 1));
          probe                <= PW'(probe + PW'(1));
        end
      end
      default: begin
        probe <= probe;
      end
    endcase
  end

  // The window never holds more frames than slots exist.
  `WAM_ASSERT_NOW(a_held_bound, 1'b1, frames_held <= HW'(WINDOW_MAX))
  // A partial frame never runs past the last probe.
  `WAM_ASSERT_NOW(a_fill_bound, 1'b1, fill_position <= PW'(PROBES - 1))
  // The divider only runs with at least one valid sample.
  `WAM_ASSERT_NOW(a_div_nonzero, state == S_DIV, cnt != '0)
  // Once the final average of a run is loaded, the block is idle again.
  `WAM_ASSERT_NEXT(a_run_end, out_load && probe == PW'(PROBES - 1), state == S_IDLE)

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the windowed per-probe average block.
`timescale 1ns / 1ps

module testbench;
  import wam_pkg::*;

  localparam int PROBES       = 32;
  localparam int WINDOW_MAX   = 16;
  localparam int CYCLE_LIMIT  = 4000000;
  localparam int DRAIN_CYCLES = 200;
  localparam int PRED_DEPTH   = 64;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_item_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SAMPLE_W-1:0]  cfg_data;

  windowed_average_with_missing #(
    .PROBES     (PROBES),
    .WINDOW_MAX (WINDOW_MAX)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the frame window and of the configuration registers.
  logic [SAMPLE_W-1:0]  frame_mem [WINDOW_MAX][PROBES];
  int unsigned          frames_kept;
  int unsigned          head_slot;
  int unsigned          fill_count;
  logic [WFRAMES_W-1:0] window_len;
  logic [SAMPLE_W-1:0]  nodata_code;

  // Averages predicted but not yet seen on the output channel, in a ring.
  out_item_t pred_buf [PRED_DEPTH];
  int        pred_head   = 0;
  int        pred_tail   = 0;
  int        pred_count  = 0;
  int        mismatches  = 0;
  int        cycle_count = 0;
  bit        quiet       = 1'b0;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Print one line per mismatch and count it.
  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("MISMATCH at cycle %0d: %s", cycle_count, what);
  endtask

  // Append one predicted average to the ring.
  function automatic void pred_put(input out_item_t item);
    pred_buf[pred_tail] = item;
    pred_tail = (pred_tail + 1) % PRED_DEPTH;
    pred_count++;
  endfunction

  // Take the oldest predicted average from the ring.
  function automatic out_item_t pred_take();
    out_item_t item;
    item = pred_buf[pred_head];
    pred_head = (pred_head + 1) % PRED_DEPTH;
    pred_count--;
    return item;
  endfunction

  // Idle cycles before a transaction or after an accepted average.
  function automatic int draw_wait();
    return quiet ? 0 : int'($urandom_range(0, 5));
  endfunction

  // Sample values weighted toward the marker and the range limits.
  function automatic logic [SAMPLE_W-1:0] draw_sample();
    case ($urandom_range(0, 9))
      0, 1, 2: return nodata_code;
      3: return 16'h7fff;
      4: return 16'h8000;
      5: return SAMPLE_W'($urandom_range(0, 6)) - 16'd3;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Retire the oldest committed frame, if any.
  function automatic void drop_oldest_frame();
    if (frames_kept > 0) begin
      head_slot = (head_slot + 1) % WINDOW_MAX;
      frames_kept--;
    end
  endfunction

  // Queue one truncated mean per probe over the frames in the window.
  function automatic void push_window_means();
    int                  sum;
    int                  cnt;
    int unsigned         slot;
    logic [SAMPLE_W-1:0] raw;
    out_item_t           avg;
    for (int p = 0; p < PROBES; p++) begin
      sum = 0;
      cnt = 0;
      for (int unsigned f = 0; f < frames_kept; f++) begin
        slot = (head_slot + f) % WINDOW_MAX;
        raw = frame_mem[slot][p];
        if (raw != nodata_code) begin
          sum = sum + $signed(raw);
          cnt++;
        end
      end
      avg.probe_index = PIDX_W'(p);
      avg.average = (cnt > 0) ? SAMPLE_W'(sum / cnt) : nodata_code;
      avg.last_of_run = (p == PROBES - 1);
      pred_put(avg);
    end
  endfunction

  // Update the shadow window with one accepted transaction.
  function automatic void track_item(input in_item_t item);
    int unsigned cap;
    int unsigned slot;
    cap = (window_len > WINDOW_MAX) ? WINDOW_MAX : window_len;
    if (item.func == FUNC_MISSING) begin
      fill_count = 0;
      drop_oldest_frame();
      push_window_means();
    end else begin
      // A partial frame fills the slot just past the newest frame.
      slot = (head_slot + frames_kept) % WINDOW_MAX;
      frame_mem[slot][fill_count % PROBES] = item.sample;
      fill_count = fill_count % PROBES + 1;
      if (fill_count == PROBES) begin
        fill_count = 0;
        frames_kept++;
        if (frames_kept > cap) begin
          drop_oldest_frame();
        end
        push_window_means();
      end
    end
  endfunction

  // Present one transaction and wait until the block takes it.
  task automatic send_item(input logic func, input logic [SAMPLE_W-1:0] value);
    int       gap;
    in_item_t item;
    gap = draw_wait();
    item.func = func;
    item.sample = value;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_item(item);
  endtask

  // One frame of samples; optionally cut short by a missing-frame report.
  task automatic send_frame(input bit allow_break);
    int cut;
    cut = PROBES;
    if (allow_break && $urandom_range(0, 7) == 0) begin
      cut = $urandom_range(1, PROBES - 1);
    end
    for (int p = 0; p < PROBES; p++) begin
      if (p == cut) begin
        send_item(FUNC_MISSING, SAMPLE_W'($urandom));
        return;
      end
      send_item(FUNC_SAMPLE, draw_sample());
    end
  endtask

  // Register write once every predicted average has been seen.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pred_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_WINDOW_FRAMES) begin
      window_len = value[WFRAMES_W-1:0];
    end else begin
      nodata_code = value;
    end
  endtask

  // Window length write with random bits above the register width.
  task automatic set_window(input int frames);
    write_reg(REG_WINDOW_FRAMES, {11'($urandom), 5'(frames)});
  endtask

  // A missing frame on an empty window yields the marker everywhere.
  task automatic test_empty_window();
    send_item(FUNC_MISSING, 16'h7fff);
  endtask

  // Two frames of limit values; the second pairs them for odd and negative sums.
  task automatic test_extreme_frames();
    logic [SAMPLE_W-1:0] first_set [8];
    logic [SAMPLE_W-1:0] second_set [8];
    first_set = '{16'h7fff, 16'h8000, 16'h8001, 16'hffff,
                  16'h0000, 16'h0001, 16'h5555, 16'haaaa};
    second_set = '{16'h7fff, 16'h8000, 16'h8000, 16'hfffe,
                   16'h0000, 16'h8001, 16'h7ffe, 16'h8000};
    for (int p = 0; p < PROBES; p++) begin
      send_item(FUNC_SAMPLE, first_set[p % 8]);
    end
    for (int p = 0; p < PROBES; p++) begin
      send_item(FUNC_SAMPLE, second_set[p % 8]);
    end
  endtask

  // Missing frames throw away partial frames and empty the window.
  task automatic test_partial_frame_discard();
    for (int i = 0; i < 7; i++) begin
      send_item(FUNC_SAMPLE, draw_sample());
    end
    send_item(FUNC_MISSING, 16'h0000);
    for (int i = 0; i < 3; i++) begin
      send_item(FUNC_SAMPLE, draw_sample());
    end
    send_item(FUNC_MISSING, 16'hffff);
    send_item(FUNC_MISSING, 16'h8000);
    send_frame(1'b0);
  endtask

  // A zero window drops the oldest frame on each commit; then a one-frame window with marker zero.
  task automatic test_zero_window();
    write_reg(REG_NODATA_MARKER, 16'h0000);
    set_window(0);
    send_frame(1'b0);
    set_window(1);
    send_frame(1'b0);
    send_item(FUNC_MISSING, SAMPLE_W'($urandom));
  endtask

  // An oversized window setting keeps every frame sent.
  task automatic test_window_capacity();
    write_reg(REG_NODATA_MARKER, 16'h7fff);
    set_window(31);
    for (int i = 0; i < 2; i++) begin
      quiet = ($urandom_range(0, 3) == 0);
      send_frame(1'b0);
    end
    quiet = 1'b0;
  endtask

  // Window length lowered below the frames held, with a new marker.
  task automatic test_lowered_window();
    write_reg(REG_NODATA_MARKER, SAMPLE_W'($urandom));
    set_window(1);
    send_frame(1'b1);
    send_item(FUNC_MISSING, SAMPLE_W'($urandom));
  endtask

  // Several settings with random frames, broken frames and lone reports.
  task automatic test_random_mix();
    int                  wlen;
    logic [SAMPLE_W-1:0] code;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin wlen = 2; code = 16'h8000; end
        1: begin wlen = 16; code = 16'h0000; end
        default: begin wlen = $urandom_range(0, 31); code = SAMPLE_W'($urandom); end
      endcase
      set_window(wlen);
      write_reg(REG_NODATA_MARKER, code);
      quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 7) == 0) begin
        send_item(FUNC_MISSING, SAMPLE_W'($urandom));
      end
      send_frame(1'b1);
    end
    quiet = 1'b0;
  endtask

  // Output side: random stall after each average, compare with the oldest prediction.
  initial begin : result_check
    int        hold;
    out_item_t want;
    hold = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (pred_count == 0) begin
          flag_mismatch($sformatf("average for probe %0d with none expected",
                                  out_data.probe_index));
        end else begin
          want = pred_take();
          if (out_data.probe_index !== want.probe_index) begin
            flag_mismatch($sformatf("probe_index %0d, expected %0d",
                                    out_data.probe_index, want.probe_index));
          end
          if (out_data.average !== want.average) begin
            flag_mismatch($sformatf("probe %0d average %0d, expected %0d",
                                    want.probe_index, out_data.average, want.average));
          end
          if (out_data.last_of_run !== want.last_of_run) begin
            flag_mismatch($sformatf("probe %0d last_of_run %b, expected %b",
                                    want.probe_index, out_data.last_of_run,
                                    want.last_of_run));
          end
        end
        hold = draw_wait();
      end else if (hold > 0) begin
        hold--;
      end
      out_stall <= (hold > 0);
    end
  end

  // Cycle limit for a hung run.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Reset, run the tests in turn, drain and report.
  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    frames_kept = 0;
    head_slot = 0;
    fill_count = 0;
    window_len = WINDOW_FRAMES_RST;
    nodata_code = NODATA_MARKER_RST;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_window();
    test_extreme_frames();
    test_partial_frame_discard();
    test_zero_window();
    test_window_capacity();
    test_lowered_window();
    test_random_mix();

    in_valid <= 1'b0;
    @(posedge clk);
    while (pred_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pred_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
